@@ hw/rtl/hashed_timing_wheel_top_assert.svh @@
// Assertion helpers for the timing wheel blocks.
// Each expects clk and rst_n to be visible in the enclosing module.
`ifndef HASHED_TIMING_WHEEL_TOP_ASSERT_SVH
`define HASHED_TIMING_WHEEL_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define HTW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define HTW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/htw_pkg.sv @@
`timescale 1ns / 1ps

package htw_pkg;

    localparam int HTW_WHEEL_SLOTS = 60;
    localparam int HTW_POOL_SIZE   = 32;
    localparam int LINK_W          = 6;
    localparam int TIMEOUT_W       = 16;
    localparam logic [LINK_W-1:0] NIL_LINK = 6'd63;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] KIND_ADDED   = 2'd0;
    localparam logic [1:0] KIND_DELETED = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;
    localparam logic [1:0] KIND_TICK    = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_UNKNOWN = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD_DIV,
        S_ADD_SLOT,
        S_ADD_LINK,
        S_DEL_COMMIT,
        S_TICK_LOAD,
        S_WALK,
        S_EXP_COMMIT,
        S_TICK_DONE
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_ADD_START,
        CMD_DIV_STEP,
        CMD_ADD_SLOT,
        CMD_ADD_LINK,
        CMD_EMIT_FULL,
        CMD_EMIT_UNKNOWN,
        CMD_DEL_READ,
        CMD_UNLINK_DEL,
        CMD_TICK_READ,
        CMD_TICK_LOAD,
        CMD_WALK_STEP,
        CMD_EXP_READ,
        CMD_UNLINK_EXP,
        CMD_TICK_DONE
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       hin_ok;
        logic       full;
        logic       div_last;
        logic       walk_more;
        logic       rot_zero;
        logic       out_free;
    } dp_status_t;

endpackage

@@ hw/rtl/htw_in_if.sv @@
`timescale 1ns / 1ps

interface htw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] timeout;
    logic [4:0]  handle;

    modport source (output valid, output op, output timeout, output handle, input ready);
    modport sink   (input valid, input op, input timeout, input handle, output ready);
endinterface

@@ hw/rtl/htw_out_if.sv @@
`timescale 1ns / 1ps

interface htw_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [1:0] status;
    logic [4:0] timer_handle;
    logic       last;

    modport source (output valid, output kind, output status, output timer_handle,
                    output last, input ready);
    modport sink   (input valid, input kind, input status, input timer_handle,
                    input last, output ready);
endinterface

@@ hw/rtl/htw_datapath.sv @@
`timescale 1ns / 1ps
`include "hashed_timing_wheel_top_assert.svh"

module htw_datapath #(
    parameter int WHEEL_SLOTS = htw_pkg::HTW_WHEEL_SLOTS,
    parameter int POOL_SIZE   = htw_pkg::HTW_POOL_SIZE
) (
    input  logic               clk,
    input  logic               rst_n,
    input  htw_pkg::cmd_t      cmd,
    output htw_pkg::dp_status_t sts,
    input  logic [1:0]         in_op,
    input  logic [15:0]        in_timeout,
    input  logic [4:0]         in_handle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_kind,
    output logic [1:0]         out_status,
    output logic [4:0]         out_handle,
    output logic               out_last
);
    import htw_pkg::*;

    localparam int SW    = $clog2(WHEEL_SLOTS);
    localparam int RW    = SW + 1;
    localparam int IW    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CW    = $clog2(POOL_SIZE + 1);
    localparam int ROT_W = $clog2(65535 / WHEEL_SLOTS + 1);
    localparam int DCW   = 1;
    // Reciprocal of the slot count, exact for every 16-bit timeout.
    localparam int MW       = TIMEOUT_W + 1;
    localparam int RECIP_SH = TIMEOUT_W + SW;
    localparam logic [MW-1:0] RECIP_M =
        MW'(((64'd1 << RECIP_SH) + 64'(WHEEL_SLOTS) - 64'd1) / 64'(WHEEL_SLOTS));

    // Timer pool
    logic [POOL_SIZE-1:0] valid_reg;
    logic [LINK_W-1:0]    next_arr [POOL_SIZE];
    logic [LINK_W-1:0]    prev_arr [POOL_SIZE];
    logic [ROT_W-1:0]     rot_arr  [POOL_SIZE];
    logic [SW-1:0]        eslot_arr[POOL_SIZE];

    // Slot heads: memory plus one written flag per slot
    logic [LINK_W-1:0]      head_mem [WHEEL_SLOTS];
    logic [WHEEL_SLOTS-1:0] hv_reg;
    logic [LINK_W-1:0]      head_q_reg;
    logic                   head_qv_reg;

    logic [1:0]          op_reg;
    logic [4:0]          hin_reg;
    logic [TIMEOUT_W-1:0] tk_reg;
    logic [TIMEOUT_W-1:0] quo_reg;
    logic [RW-1:0]       rem_reg;
    logic [DCW-1:0]      cnt_reg;
    logic [SW-1:0]       cur_reg;
    logic [SW-1:0]       slot_reg;
    logic [IW-1:0]       free_h_reg;
    logic                full_reg;
    logic [LINK_W-1:0]   p_reg;
    logic [CW-1:0]       steps_reg;
    logic [LINK_W-1:0]   u_h_reg;
    logic [LINK_W-1:0]   u_nx_reg;
    logic [LINK_W-1:0]   u_pv_reg;
    logic [SW-1:0]       u_s_reg;
    logic                out_valid_reg;
    logic [1:0]          kind_reg;
    logic [1:0]          status_reg;
    logic [4:0]          th_reg;
    logic                last_reg;

    logic [LINK_W-1:0] hin_link;
    logic [IW-1:0]     ld_idx;
    logic [IW-1:0]     p_idx;
    logic [TIMEOUT_W+MW-1:0] recip_prod;
    logic [TIMEOUT_W-1:0]    quo_next;
    logic [TIMEOUT_W-1:0]    quo_times;
    logic [RW-1:0]           rem_next;
    logic [RW-1:0]     slot_sum;
    logic [SW-1:0]     slot_new;
    logic [LINK_W-1:0] headval;
    logic [LINK_W-1:0] newhead;
    logic              head_is_h;
    logic              free_found;
    logic [IW-1:0]     free_idx;
    logic              hd_re;
    logic [SW-1:0]     hd_ra;
    logic              hd_we;
    logic [SW-1:0]     hd_wa;
    logic [LINK_W-1:0] hd_wd;
    logic              emit;
    logic              out_free;

    function automatic logic link_ok(input logic [LINK_W-1:0] x,
                                     input logic [POOL_SIZE-1:0] v);
        logic r;
        r = (x < LINK_W'(POOL_SIZE)) && v[x[IW-1:0]];
        return r;
    endfunction

    assign hin_link = LINK_W'(hin_reg);
    assign ld_idx   = (cmd == CMD_DEL_READ) ? hin_link[IW-1:0] : p_reg[IW-1:0];
    assign p_idx    = p_reg[IW-1:0];
    // Quotient in the first step, remainder from it in the second.
    assign recip_prod = {{MW{1'b0}}, tk_reg} * {{TIMEOUT_W{1'b0}}, RECIP_M};
    assign quo_next   = TIMEOUT_W'(recip_prod >> RECIP_SH);
    assign quo_times  = quo_reg * TIMEOUT_W'(WHEEL_SLOTS);
    assign rem_next   = RW'(tk_reg - quo_times);
    assign slot_sum = {1'b0, cur_reg} + rem_reg;
    assign headval  = head_qv_reg ? head_q_reg : NIL_LINK;
    assign head_is_h = (headval == u_h_reg);
    assign newhead  = head_is_h ? u_nx_reg : headval;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        slot_new = (slot_sum >= RW'(WHEEL_SLOTS)) ? SW'(slot_sum - RW'(WHEEL_SLOTS))
                                                  : slot_sum[SW-1:0];
    end

    // Lowest free handle
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = POOL_SIZE - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    always_comb
    begin
        hd_re = 1'b0;
        hd_ra = cur_reg;
        hd_we = 1'b0;
        hd_wa = u_s_reg;
        hd_wd = u_nx_reg;
        emit  = 1'b0;
        case (cmd)
            CMD_ADD_SLOT:
            begin
                hd_re = 1'b1;
                hd_ra = slot_new;
            end
            CMD_DEL_READ, CMD_EXP_READ:
            begin
                hd_re = 1'b1;
                hd_ra = eslot_arr[ld_idx];
            end
            CMD_TICK_READ:
            begin
                hd_re = 1'b1;
                hd_ra = cur_reg;
            end
            CMD_ADD_LINK:
            begin
                hd_we = 1'b1;
                hd_wa = slot_reg;
                hd_wd = LINK_W'(free_h_reg);
                emit  = 1'b1;
            end
            CMD_UNLINK_DEL, CMD_UNLINK_EXP:
            begin
                hd_we = head_is_h;
                emit  = 1'b1;
            end
            CMD_EMIT_FULL, CMD_EMIT_UNKNOWN, CMD_TICK_DONE:
            begin
                emit = 1'b1;
            end
            default:
            begin
                hd_re = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        sts.op        = op_reg;
        sts.hin_ok    = link_ok(hin_link, valid_reg);
        sts.full      = full_reg;
        sts.div_last  = (cnt_reg == DCW'(1));
        sts.walk_more = link_ok(p_reg, valid_reg) && (steps_reg < CW'(POOL_SIZE));
        sts.rot_zero  = (rot_arr[p_idx] == '0);
        sts.out_free  = out_free;
    end

    // Head memory
    always_ff @(posedge clk)
    begin
        if (hd_we)
        begin
            head_mem[hd_wa] <= hd_wd;
        end
        if (hd_re)
        begin
            head_q_reg <= head_mem[hd_ra];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            hv_reg        <= '0;
            head_qv_reg   <= 1'b0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            steps_reg     <= '0;
            full_reg      <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (hd_we)
            begin
                hv_reg[hd_wa] <= 1'b1;
            end
            if (hd_re)
            begin
                head_qv_reg <= hv_reg[hd_ra];
            end
            case (cmd)
                CMD_LATCH:     cnt_reg <= '0;
                CMD_DIV_STEP:  cnt_reg <= cnt_reg + 1'b1;
                CMD_ADD_START: full_reg <= !free_found;
                CMD_ADD_LINK:  valid_reg[free_h_reg] <= 1'b1;
                CMD_UNLINK_DEL, CMD_UNLINK_EXP:
                begin
                    valid_reg[u_h_reg[IW-1:0]] <= 1'b0;
                end
                CMD_TICK_LOAD: steps_reg <= '0;
                CMD_WALK_STEP, CMD_EXP_READ:
                begin
                    steps_reg <= steps_reg + 1'b1;
                end
                CMD_TICK_DONE:
                begin
                    cur_reg <= (cur_reg == SW'(WHEEL_SLOTS - 1)) ? '0 : cur_reg + 1'b1;
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    // Payload and pool arrays
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LATCH:
            begin
                op_reg  <= in_op;
                hin_reg <= in_handle;
                tk_reg  <= (in_timeout == '0) ? TIMEOUT_W'(1) : in_timeout;
                rem_reg <= '0;
            end
            CMD_ADD_START:
            begin
                free_h_reg <= free_idx;
            end
            CMD_DIV_STEP:
            begin
                if (cnt_reg == '0)
                begin
                    quo_reg <= quo_next;
                end
                else
                begin
                    rem_reg <= rem_next;
                end
            end
            CMD_ADD_SLOT:
            begin
                slot_reg <= slot_new;
            end
            CMD_ADD_LINK:
            begin
                next_arr[free_h_reg]  <= link_ok(headval, valid_reg) ? headval : NIL_LINK;
                prev_arr[free_h_reg]  <= NIL_LINK;
                rot_arr[free_h_reg]   <= quo_reg[ROT_W-1:0];
                eslot_arr[free_h_reg] <= slot_reg;
                if (link_ok(headval, valid_reg))
                begin
                    prev_arr[headval[IW-1:0]] <= LINK_W'(free_h_reg);
                end
                kind_reg   <= KIND_ADDED;
                status_reg <= STAT_OK;
                th_reg     <= 5'(free_h_reg);
                last_reg   <= 1'b1;
            end
            CMD_EMIT_FULL:
            begin
                kind_reg   <= KIND_ADDED;
                status_reg <= STAT_FULL;
                th_reg     <= '0;
                last_reg   <= 1'b1;
            end
            CMD_EMIT_UNKNOWN:
            begin
                kind_reg   <= KIND_DELETED;
                status_reg <= STAT_UNKNOWN;
                th_reg     <= hin_reg;
                last_reg   <= 1'b1;
            end
            CMD_DEL_READ, CMD_EXP_READ:
            begin
                u_h_reg  <= LINK_W'(ld_idx);
                u_nx_reg <= next_arr[ld_idx];
                u_pv_reg <= prev_arr[ld_idx];
                u_s_reg  <= eslot_arr[ld_idx];
            end
            CMD_UNLINK_DEL, CMD_UNLINK_EXP:
            begin
                if (!head_is_h && link_ok(u_pv_reg, valid_reg))
                begin
                    next_arr[u_pv_reg[IW-1:0]] <= u_nx_reg;
                end
                if (link_ok(u_nx_reg, valid_reg))
                begin
                    prev_arr[u_nx_reg[IW-1:0]] <= (newhead == u_nx_reg) ? NIL_LINK : u_pv_reg;
                end
                status_reg <= STAT_OK;
                th_reg     <= u_h_reg[4:0];
                if (cmd == CMD_UNLINK_DEL)
                begin
                    kind_reg <= KIND_DELETED;
                    last_reg <= 1'b1;
                end
                else
                begin
                    kind_reg <= KIND_EXPIRED;
                    last_reg <= 1'b0;
                    p_reg    <= u_nx_reg;
                end
            end
            CMD_TICK_LOAD:
            begin
                p_reg <= headval;
            end
            CMD_WALK_STEP:
            begin
                rot_arr[p_idx] <= rot_arr[p_idx] - 1'b1;
                p_reg          <= next_arr[p_idx];
            end
            CMD_TICK_DONE:
            begin
                kind_reg   <= KIND_TICK;
                status_reg <= STAT_OK;
                th_reg     <= '0;
                last_reg   <= 1'b1;
            end
            default:
            begin
                op_reg <= op_reg;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = kind_reg;
    assign out_status = status_reg;
    assign out_handle = th_reg;
    assign out_last   = last_reg;

    `HTW_ASSERT_IMP(a_cur_in_range, 1'b1, {1'b0, cur_reg} < RW'(WHEEL_SLOTS), "slot out of range")
    `HTW_ASSERT_NXT(a_add_sets_valid, cmd == CMD_ADD_LINK, valid_reg[$past(free_h_reg)], "add lost")
    `HTW_ASSERT_NXT(a_unlink_frees, cmd == CMD_UNLINK_DEL || cmd == CMD_UNLINK_EXP, !valid_reg[$past(u_h_reg[IW-1:0])], "unlink kept entry")
    `HTW_ASSERT_IMP(a_emit_room, emit, out_free, "result overwritten")

endmodule

@@ hw/rtl/htw_ctrl.sv @@
`timescale 1ns / 1ps

module htw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  htw_pkg::dp_status_t sts,
    output htw_pkg::cmd_t       cmd
);
    import htw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = CMD_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.op)
                    OP_ADD:
                    begin
                        cmd        = CMD_ADD_START;
                        state_next = S_ADD_DIV;
                    end
                    OP_DEL:
                    begin
                        if (sts.hin_ok)
                        begin
                            cmd        = CMD_DEL_READ;
                            state_next = S_DEL_COMMIT;
                        end
                        else if (sts.out_free)
                        begin
                            cmd        = CMD_EMIT_UNKNOWN;
                            state_next = S_IDLE;
                        end
                    end
                    OP_TICK:
                    begin
                        cmd        = CMD_TICK_READ;
                        state_next = S_TICK_LOAD;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_ADD_DIV:
            begin
                cmd = CMD_DIV_STEP;
                if (sts.div_last)
                begin
                    state_next = S_ADD_SLOT;
                end
            end
            S_ADD_SLOT:
            begin
                if (!sts.full)
                begin
                    cmd        = CMD_ADD_SLOT;
                    state_next = S_ADD_LINK;
                end
                else if (sts.out_free)
                begin
                    cmd        = CMD_EMIT_FULL;
                    state_next = S_IDLE;
                end
            end
            S_ADD_LINK:
            begin
                if (sts.out_free)
                begin
                    cmd        = CMD_ADD_LINK;
                    state_next = S_IDLE;
                end
            end
            S_DEL_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd        = CMD_UNLINK_DEL;
                    state_next = S_IDLE;
                end
            end
            S_TICK_LOAD:
            begin
                cmd        = CMD_TICK_LOAD;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (!sts.walk_more)
                begin
                    state_next = S_TICK_DONE;
                end
                else if (sts.rot_zero)
                begin
                    cmd        = CMD_EXP_READ;
                    state_next = S_EXP_COMMIT;
                end
                else
                begin
                    cmd = CMD_WALK_STEP;
                end
            end
            S_EXP_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd        = CMD_UNLINK_EXP;
                    state_next = S_WALK;
                end
            end
            S_TICK_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd        = CMD_TICK_DONE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/hashed_timing_wheel_top.sv @@
`timescale 1ns / 1ps
// Hashed timing wheel with rotation counts and a pool of timers.
// Requests arrive on req (op, timeout, handle); results leave on rsp
// (kind, status, timer_handle, last), each a valid/ready transaction.
// One request is worked at a time: req.ready is high only while the
// controller is idle, and a finished result sits in the rsp register so
// that the next request can be taken while it waits.
// In an add, a reciprocal multiplication and a multiply-back give the
// rotation count and slot, and the later states read and relink the
// slot head. A delete reads the entry and then unlinks it; an unknown
// handle is answered from the dispatch state.
// A tick reads the slot head and walks its list, up to the pool size: a
// timer that only counts down takes one walk step, and one that expires
// is read and then unlinked.
// Results of one tick leave newest timer first, then a tick-done result
// with last set. A stalled rsp halts the block when it must emit.
// Reset empties every slot, frees every handle and returns to slot zero;
// it takes effect at once, with no clearing pass.
module hashed_timing_wheel_top #(
    parameter int WHEEL_SLOTS = htw_pkg::HTW_WHEEL_SLOTS,
    parameter int POOL_SIZE   = htw_pkg::HTW_POOL_SIZE
) (
    input logic clk,
    input logic rst_n,
    htw_in_if.sink    req,
    htw_out_if.source rsp
);
    import htw_pkg::*;

    cmd_t       cmd;
    dp_status_t sts;

    // The controller sequences each request; the datapath holds the wheel state.
    htw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    htw_datapath #(
        .WHEEL_SLOTS (WHEEL_SLOTS),
        .POOL_SIZE   (POOL_SIZE)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (req.op),
        .in_timeout (req.timeout),
        .in_handle  (req.handle),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_kind   (rsp.kind),
        .out_status (rsp.status),
        .out_handle (rsp.timer_handle),
        .out_last   (rsp.last)
    );

endmodule

@@ dv/htw_tb_pkg.sv @@
`timescale 1ns / 1ps

package htw_tb_pkg;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] timeout;
        logic [4:0]  handle;
    } wheel_request_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] status;
        logic [4:0] timer_handle;
        logic       last;
    } wheel_result_t;

endpackage

@@ dv/tb_hashed_timing_wheel_top.sv @@
`timescale 1ns / 1ps

module tb_hashed_timing_wheel_top;
    import htw_pkg::*;
    import htw_tb_pkg::*;

    localparam int SLOTS = HTW_WHEEL_SLOTS;
    localparam int POOL  = HTW_POOL_SIZE;
    localparam logic [5:0] EMPTY = 6'd63;

    logic clk;
    logic rst_n;

    htw_in_if  req_if ();
    htw_out_if rsp_if ();

    hashed_timing_wheel_top i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if.sink),
        .rsp  (rsp_if.source)
    );

    // Shadow copy of the wheel, kept in step with every accepted request.
    logic [5:0]  shadow_head [SLOTS];
    logic [5:0]  shadow_next [POOL];
    logic [5:0]  shadow_prev [POOL];
    int unsigned shadow_rot  [POOL];
    int unsigned shadow_slot [POOL];
    bit          shadow_live [POOL];
    int unsigned shadow_cur;

    wheel_request_t pending_requests[$];
    wheel_result_t  expected_results[$];
    int             mismatch_count;
    bit             stimulus_done;
    bit             req_accepted;
    bit             rsp_accepted;

    always #10 clk = ~clk;

    function automatic bit is_live(int unsigned h);
        return h < POOL && shadow_live[h];
    endfunction

    // Removes a timer from its slot's list, patching the neighbours.
    function automatic void detach_timer(int unsigned h);
        int unsigned s;
        int unsigned nx;
        int unsigned pv;
        s  = shadow_slot[h] % SLOTS;
        nx = shadow_next[h];
        pv = shadow_prev[h];
        if (shadow_head[s] == h)
            shadow_head[s] = nx[5:0];
        else if (is_live(pv))
            shadow_next[pv] = nx[5:0];
        if (is_live(nx))
            shadow_prev[nx] = (shadow_head[s] == nx) ? EMPTY : pv[5:0];
        shadow_live[h] = 1'b0;
    endfunction

    function automatic void push_result(logic [1:0] k, logic [1:0] st, int unsigned h,
                                        logic lst);
        wheel_result_t r;
        r.kind         = k;
        r.status       = st;
        r.timer_handle = h[4:0];
        r.last         = lst;
        expected_results.push_back(r);
    endfunction

    // Works out the results of one accepted request and updates the shadow wheel.
    function automatic void predict_wheel(wheel_request_t q);
        int unsigned h;
        int unsigned ticks;
        int unsigned s;
        int unsigned p;
        int unsigned nx;
        int unsigned steps;
        case (q.op)
            OP_ADD:
            begin
                h = 0;
                while (h < POOL && shadow_live[h])
                    h++;
                if (h >= POOL)
                begin
                    push_result(KIND_ADDED, STAT_FULL, 0, 1'b1);
                end
                else
                begin
                    ticks = (q.timeout == 0) ? 1 : q.timeout;
                    s = (shadow_cur + ticks % SLOTS) % SLOTS;
                    shadow_rot[h]  = ticks / SLOTS;
                    shadow_slot[h] = s;
                    shadow_prev[h] = EMPTY;
                    shadow_next[h] = is_live(shadow_head[s]) ? shadow_head[s] : EMPTY;
                    if (is_live(shadow_head[s]))
                        shadow_prev[shadow_head[s]] = h[5:0];
                    shadow_head[s] = h[5:0];
                    shadow_live[h] = 1'b1;
                    push_result(KIND_ADDED, STAT_OK, h, 1'b1);
                end
            end
            OP_DEL:
            begin
                if (!is_live(q.handle))
                    push_result(KIND_DELETED, STAT_UNKNOWN, q.handle, 1'b1);
                else
                begin
                    detach_timer(q.handle);
                    push_result(KIND_DELETED, STAT_OK, q.handle, 1'b1);
                end
            end
            OP_TICK:
            begin
                steps = 0;
                p = shadow_head[shadow_cur];
                while (is_live(p) && steps < POOL)
                begin
                    nx = shadow_next[p];
                    steps++;
                    if (shadow_rot[p] > 0)
                        shadow_rot[p]--;
                    else
                    begin
                        detach_timer(p);
                        push_result(KIND_EXPIRED, STAT_OK, p, 1'b0);
                    end
                    p = nx;
                end
                push_result(KIND_TICK, STAT_OK, 0, 1'b1);
                shadow_cur = (shadow_cur + 1) % SLOTS;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Handshakes are seen at the rising edge; the driver and the sink act on them
    // at the following falling edge.
    always @(posedge clk)
    begin
        req_accepted <= rst_n && req_if.valid && req_if.ready;
        rsp_accepted <= rst_n && rsp_if.valid && rsp_if.ready;
        if (rst_n && req_if.valid && req_if.ready)
            predict_wheel(pending_requests.pop_front());
    end

    // Driver: takes requests from the queue, with a random gap before each one.
    int gap_left;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_accepted)
            begin
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
                req_if.valid <= 1'b0;
            end
            else if (!req_if.valid && pending_requests.size() > 0)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else
                begin
                    req_if.valid   <= 1'b1;
                    req_if.op      <= pending_requests[0].op;
                    req_if.timeout <= pending_requests[0].timeout;
                    req_if.handle  <= pending_requests[0].handle;
                end
            end
        end
    end

    // Sink side: a random stall before each result, also changed at the falling edge.
    int stall_left;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_accepted)
            begin
                stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
                rsp_if.ready <= 1'b0;
            end
            else if (!rsp_if.ready)
            begin
                if (stall_left > 0)
                    stall_left <= stall_left - 1;
                else
                    rsp_if.ready <= 1'b1;
            end
        end
    end

    // Monitor: every accepted result is matched against the oldest expectation.
    always @(posedge clk)
    begin
        wheel_result_t seen;
        wheel_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            seen = '{rsp_if.kind, rsp_if.status, rsp_if.timer_handle, rsp_if.last};
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: kind %0d status %0d handle %0d last %0d",
                             seen.kind, seen.status, seen.timer_handle, seen.last);
            end
            else
            begin
                want = expected_results.pop_front();
                if (seen !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.kind, want.status, want.timer_handle, want.last,
                                 seen.kind, seen.status, seen.timer_handle, seen.last);
                end
            end
        end
    end

    function automatic void queue_request(logic [1:0] o, logic [15:0] t, logic [4:0] h);
        wheel_request_t q;
        q.op      = o;
        q.timeout = t;
        q.handle  = h;
        pending_requests.push_back(q);
    endfunction

    // Stimulus. Directed part first: timeout zero, one and the largest value, slot
    // wrap, delete of a middle and of unknown handles, the unused opcode, a pool
    // that fills up, and ticks that expire several timers in one slot.
    initial
    begin
        int n;
        int r;
        clk = 1'b0;
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.op = OP_ADD;
        req_if.timeout = '0;
        req_if.handle = '0;
        rsp_if.ready = 1'b0;
        gap_left = 0;
        stall_left = 0;
        mismatch_count = 0;
        stimulus_done = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            shadow_head[i] = EMPTY;
        for (int i = 0; i < POOL; i++)
            shadow_live[i] = 1'b0;
        shadow_cur = 0;

        queue_request(OP_ADD, 16'd0, 5'd0);
        queue_request(OP_ADD, 16'd1, 5'd31);
        queue_request(OP_ADD, 16'd1, 5'd0);
        queue_request(OP_ADD, 16'd61, 5'd0);
        queue_request(OP_ADD, 16'hFFFF, 5'd0);
        queue_request(OP_DEL, 16'hFFFF, 5'd2);
        queue_request(OP_DEL, 16'd0, 5'd2);
        queue_request(OP_DEL, 16'd0, 5'd31);
        queue_request(2'd3, 16'hFFFF, 5'd31);
        queue_request(OP_TICK, 16'd0, 5'd0);
        queue_request(OP_TICK, 16'd0, 5'd0);
        // Fill the pool, then one more add to hit the full case.
        for (int i = 0; i < POOL; i++)
            queue_request(OP_ADD, 16'd2, 5'd0);
        queue_request(OP_ADD, 16'd5, 5'd0);
        queue_request(OP_TICK, 16'd0, 5'd0);
        queue_request(OP_TICK, 16'd0, 5'd0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Random part: mostly adds with short timeouts and ticks, so that timers
        // really expire, with deletes aimed at likely live handles.
        for (n = 0; n < 84; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                queue_request(OP_ADD, ($urandom_range(0, 4) == 0) ? 16'($urandom)
                              : 16'($urandom_range(0, 130)), 5'($urandom));
            else if (r < 50)
                queue_request(OP_DEL, 16'($urandom), ($urandom_range(0, 1) == 0) ?
                              5'($urandom_range(0, 7)) : 5'($urandom));
            else if (r < 97)
                queue_request(OP_TICK, 16'($urandom), 5'($urandom));
            else
                queue_request(2'd3, 16'($urandom), 5'($urandom));
        end

        wait (pending_requests.size() == 0 && !req_if.valid);
        wait (expected_results.size() == 0);
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog on the whole run.
    initial
    begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
